// ===== rtl/sigseg_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted index group segmenter: shared types and constants
// Record kinds, error codes, the queue entry built by the front end and the
// output record assembled by the back end.
// ----------------------------------------------------------------------------
package sigseg_pkg;

   localparam int FULL_SIZE_W = 21;
   localparam int GROUP_W     = 32;
   localparam int ROW_W       = 32;
   localparam int RSP_DATA_W  = 136;

   // Record kind, travels on tuser
   typedef enum logic [1:0] {
      KIND_ASSIGNED   = 2'd0,
      KIND_RANGE      = 2'd1,
      KIND_UNASSIGNED = 2'd2,
      KIND_ERROR      = 2'd3
   } rec_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_ASG_UNSORTED = 3'd1,
      ERR_ASG_SPLIT    = 3'd2,
      ERR_UNA_UNSORTED = 3'd3,
      ERR_UNA_SPLIT    = 3'd4
   } err_code_type;

   // Record slots of one queue entry, in emission order
   localparam int SLOT_COUNT = 5;
   localparam logic [2:0] REC_RNG_A = 3'd0;
   localparam logic [2:0] REC_SLC_A = 3'd1;
   localparam logic [2:0] REC_RNG_B = 3'd2;
   localparam logic [2:0] REC_SLC_B = 3'd3;
   localparam logic [2:0] REC_PAD   = 3'd4;

   // One closed run: its slice and the empty range in front of it
   typedef struct packed {
      rec_kind_type              kind;
      err_code_type              err;
      logic signed [GROUP_W-1:0] value;
      logic [ROW_W-1:0]          offset;
      logic [ROW_W-1:0]          count;
      logic [GROUP_W-1:0]        rng_first;
   } slot_type;

   typedef struct packed {
      logic [SLOT_COUNT-1:0] mask;
      slot_type              slot_a;
      slot_type              slot_b;
      logic [GROUP_W-1:0]    pad_first;
      logic [GROUP_W-1:0]    pad_end;
      logic [ROW_W-1:0]      pad_offset;
      logic                  col_last;
   } entry_type;

   typedef struct packed {
      rec_kind_type       kind;
      logic [GROUP_W-1:0] first;
      logic [GROUP_W-1:0] group_end;
      logic [ROW_W-1:0]   offset;
      logic [ROW_W-1:0]   count;
      err_code_type       err;
      logic               last;
   } record_type;

endpackage

// ===== rtl/sigseg_front.sv =====
// ----------------------------------------------------------------------------
// Segmenter front end
// Checks each row against the ordering rules, tracks the run in progress and,
// up to the first error, queues one entry per run close, error or column end.
// ----------------------------------------------------------------------------
module sigseg_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [sigseg_pkg::FULL_SIZE_W-1:0]    full_size,
   input  logic                                  row_accept,
   input  logic [sigseg_pkg::GROUP_W-1:0]        index_value,
   input  logic                                  last_row,
   output logic                                  push,
   output sigseg_pkg::entry_type                 push_entry
);

   // Column state
   logic signed [31:0] run_value_ff, run_value_in;
   logic signed [31:0] highest_ff, highest_in;
   logic signed [31:0] lowest_ff, lowest_in;
   logic [31:0]        run_start_ff, run_start_in;
   logic [31:0]        row_ff, row_in;
   logic [31:0]        leg_ff, leg_in;
   logic               any_ff, any_in;
   logic               first_pending_ff, first_pending_in;
   logic               error_seen_ff, error_seen_in;

   logic signed [31:0]     v;
   logic                   assigned_v;
   sigseg_pkg::err_code_type err;
   logic                   change, close_a;
   logic signed [32:0]     nfg0, nfg1, nfg2, rv_ext, v_ext, end_grp;
   logic                   rng_a, rng_b, has_pad;
   logic [31:0]            leg1, leg2;
   logic                   any1, any2;
   logic [31:0]            rs1, row1;

   // Classify the row
   always_comb begin
      v          = signed'(index_value);
      assigned_v = !v[31];
      err        = sigseg_pkg::ERR_NONE;
      if (!first_pending_ff) begin
         if (assigned_v) begin
            if (highest_ff > v)
               err = sigseg_pkg::ERR_ASG_UNSORTED;
            else if (highest_ff == v && run_value_ff[31])
               err = sigseg_pkg::ERR_ASG_SPLIT;
         end else begin
            if (lowest_ff < v)
               err = sigseg_pkg::ERR_UNA_UNSORTED;
            else if (lowest_ff == v && !run_value_ff[31])
               err = sigseg_pkg::ERR_UNA_SPLIT;
         end
      end
   end

   // Work out the run closings and the free-group chain
   always_comb begin
      change  = first_pending_ff || (v != run_value_ff);
      close_a = !first_pending_ff && change;
      rv_ext  = {run_value_ff[31], run_value_ff};
      v_ext   = {v[31], v};

      nfg0  = any_ff ? signed'({1'b0, leg_ff} + 33'd1) : 33'sd0;
      rng_a = !run_value_ff[31] && (nfg0 <= rv_ext - 33'sd1);
      leg1  = (close_a && !run_value_ff[31]) ? run_value_ff : leg_ff;
      any1  = any_ff || (close_a && !run_value_ff[31]);

      rs1  = change ? row_ff : run_start_ff;
      row1 = row_ff + 32'd1;

      nfg1  = any1 ? signed'({1'b0, leg1} + 33'd1) : 33'sd0;
      rng_b = assigned_v && (nfg1 <= v_ext - 33'sd1);
      leg2  = assigned_v ? v : leg1;
      any2  = any1 || assigned_v;

      nfg2    = any2 ? signed'({1'b0, leg2} + 33'd1) : 33'sd0;
      end_grp = signed'({12'b0, full_size}) - 33'sd1;
      has_pad = (nfg2 <= end_grp);
   end

   // Build the queue entry
   always_comb begin
      push_entry.slot_a.kind      = run_value_ff[31] ? sigseg_pkg::KIND_UNASSIGNED
                                                     : sigseg_pkg::KIND_ASSIGNED;
      push_entry.slot_a.err       = sigseg_pkg::ERR_NONE;
      push_entry.slot_a.value     = run_value_ff;
      push_entry.slot_a.offset    = run_start_ff;
      push_entry.slot_a.count     = row_ff - run_start_ff;
      push_entry.slot_a.rng_first = nfg0[31:0];
      push_entry.pad_first        = nfg2[31:0];
      push_entry.pad_end          = end_grp[31:0];
      push_entry.pad_offset       = row1;
      if (err != sigseg_pkg::ERR_NONE) begin
         push_entry.slot_b.kind      = sigseg_pkg::KIND_ERROR;
         push_entry.slot_b.err       = err;
         push_entry.slot_b.value     = v;
         push_entry.slot_b.offset    = row_ff;
         push_entry.slot_b.count     = '0;
         push_entry.slot_b.rng_first = '0;
         push_entry.mask             = '0;
         push_entry.mask[sigseg_pkg::REC_SLC_B] = 1'b1;
         push_entry.col_last         = 1'b1;
      end else begin
         push_entry.slot_b.kind      = assigned_v ? sigseg_pkg::KIND_ASSIGNED
                                                  : sigseg_pkg::KIND_UNASSIGNED;
         push_entry.slot_b.err       = sigseg_pkg::ERR_NONE;
         push_entry.slot_b.value     = v;
         push_entry.slot_b.offset    = rs1;
         push_entry.slot_b.count     = row1 - rs1;
         push_entry.slot_b.rng_first = nfg1[31:0];
         push_entry.mask             = '0;
         push_entry.mask[sigseg_pkg::REC_RNG_A] = close_a && rng_a;
         push_entry.mask[sigseg_pkg::REC_SLC_A] = close_a;
         push_entry.mask[sigseg_pkg::REC_RNG_B] = last_row && rng_b;
         push_entry.mask[sigseg_pkg::REC_SLC_B] = last_row;
         push_entry.mask[sigseg_pkg::REC_PAD]   = last_row && has_pad;
         push_entry.col_last         = last_row;
      end
      push = row_accept && !error_seen_ff &&
             ((err != sigseg_pkg::ERR_NONE) || close_a || last_row);
   end

   // Advance the column state
   always_comb begin
      run_value_in     = run_value_ff;
      highest_in       = highest_ff;
      lowest_in        = lowest_ff;
      run_start_in     = run_start_ff;
      row_in           = row_ff;
      leg_in           = leg_ff;
      any_in           = any_ff;
      first_pending_in = first_pending_ff;
      error_seen_in    = error_seen_ff;
      if (row_accept) begin
         if (last_row) begin
            run_value_in     = '0;
            highest_in       = -32'sd1;
            lowest_in        = '0;
            run_start_in     = '0;
            row_in           = '0;
            leg_in           = '0;
            any_in           = 1'b0;
            first_pending_in = 1'b1;
            error_seen_in    = 1'b0;
         end else if (error_seen_ff) begin
            error_seen_in = 1'b1;
         end else if (err != sigseg_pkg::ERR_NONE) begin
            error_seen_in = 1'b1;
         end else begin
            run_value_in     = v;
            run_start_in     = rs1;
            row_in           = row1;
            leg_in           = leg1;
            any_in           = any1;
            first_pending_in = 1'b0;
            if (assigned_v)
               highest_in = v;
            else
               lowest_in = v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff     <= '0;
         highest_ff       <= -32'sd1;
         lowest_ff        <= '0;
         run_start_ff     <= '0;
         row_ff           <= '0;
         leg_ff           <= '0;
         any_ff           <= 1'b0;
         first_pending_ff <= 1'b1;
         error_seen_ff    <= 1'b0;
      end else begin
         run_value_ff     <= run_value_in;
         highest_ff       <= highest_in;
         lowest_ff        <= lowest_in;
         run_start_ff     <= run_start_in;
         row_ff           <= row_in;
         leg_ff           <= leg_in;
         any_ff           <= any_in;
         first_pending_ff <= first_pending_in;
         error_seen_ff    <= error_seen_in;
      end
   end

endmodule

// ===== rtl/sigseg_queue.sv =====
// ----------------------------------------------------------------------------
// Segmenter command queue
// Small circular buffer of entries between the front end and the back end.
// ----------------------------------------------------------------------------
module sigseg_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sigseg_pkg::entry_type push_entry,
   input  logic                  pop,
   output sigseg_pkg::entry_type head,
   output logic                  not_empty,
   output logic                  full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sigseg_pkg::entry_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign head      = store_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == CNT_W'(DEPTH));

   // Advance pointers and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push)
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (pop)
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      if (push && !pop)
         cnt_in = cnt_ff + CNT_W'(1);
      else if (pop && !push)
         cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Write the entry
   always_ff @(posedge clock) begin
      if (push)
         store_ff[wr_ff] <= push_entry;
   end

endmodule

// ===== rtl/sigseg_back.sv =====
// ----------------------------------------------------------------------------
// Segmenter back end
// Expands each queue entry into its records, one word a cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module sigseg_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sigseg_pkg::entry_type  head,
   input  logic                   head_valid,
   output logic                   pop,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output sigseg_pkg::record_type rsp_rec
);

   sigseg_pkg::entry_type  work_ff, cur;
   logic [sigseg_pkg::SLOT_COUNT-1:0] mask_ff, cur_mask, rest;
   logic                   use_head, out_free, emit;
   logic [2:0]             sel;
   sigseg_pkg::record_type rec, rsp_rec_ff;
   logic                   rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rec   = rsp_rec_ff;

   // Pick the next record: the entry in work, or else the queue head
   always_comb begin
      use_head = (mask_ff == '0);
      cur      = use_head ? head : work_ff;
      cur_mask = use_head ? (head_valid ? head.mask : '0) : mask_ff;
      out_free = !rsp_valid_ff || rsp_ready;
      emit     = out_free && (cur_mask != '0);
      pop      = emit && use_head;
      sel      = sigseg_pkg::REC_PAD;
      for (int i = sigseg_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (cur_mask[i])
            sel = 3'(i);
      end
      rest = cur_mask & ~(sigseg_pkg::SLOT_COUNT'(1) << sel);
   end

   // Assemble the record fields
   always_comb begin
      rec.err   = sigseg_pkg::ERR_NONE;
      rec.count = '0;
      case (sel)
         sigseg_pkg::REC_RNG_A: begin
            rec.kind      = sigseg_pkg::KIND_RANGE;
            rec.first     = cur.slot_a.rng_first;
            rec.group_end = cur.slot_a.value - 32'sd1;
            rec.offset    = cur.slot_a.offset;
         end
         sigseg_pkg::REC_SLC_A: begin
            rec.kind      = cur.slot_a.kind;
            rec.first     = cur.slot_a.value;
            rec.group_end = cur.slot_a.value;
            rec.offset    = cur.slot_a.offset;
            rec.count     = cur.slot_a.count;
            rec.err       = cur.slot_a.err;
         end
         sigseg_pkg::REC_RNG_B: begin
            rec.kind      = sigseg_pkg::KIND_RANGE;
            rec.first     = cur.slot_b.rng_first;
            rec.group_end = cur.slot_b.value - 32'sd1;
            rec.offset    = cur.slot_b.offset;
         end
         sigseg_pkg::REC_SLC_B: begin
            rec.kind      = cur.slot_b.kind;
            rec.first     = cur.slot_b.value;
            rec.group_end = cur.slot_b.value;
            rec.offset    = cur.slot_b.offset;
            rec.count     = cur.slot_b.count;
            rec.err       = cur.slot_b.err;
         end
         default: begin
            rec.kind      = sigseg_pkg::KIND_RANGE;
            rec.first     = cur.pad_first;
            rec.group_end = cur.pad_end;
            rec.offset    = cur.pad_offset;
         end
      endcase
      rec.last = cur.col_last && (rest == '0);
   end

   // Control: pending slots and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         mask_ff      <= rest;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload: hold the entry in work and load the output word
   always_ff @(posedge clock) begin
      if (emit) begin
         work_ff    <= cur;
         rsp_rec_ff <= rec;
      end
   end

endmodule

// ===== rtl/sorted_index_group_segmenter_core.sv =====
// ----------------------------------------------------------------------------
// Sorted index group segmenter core
// Cuts a column of signed group indices into assigned and unassigned slices,
// fills skipped groups with empty ranges and reports ordering errors.
// ----------------------------------------------------------------------------
// The block takes one row per cycle; a row only stalls when the entry queue
// between the front end and the back end (QUEUE_DEPTH entries) is full. A row
// that closes a run or ends the column makes one entry worth one to five
// records, and the back end drains them at one word per cycle while rsp_tready
// is high, through a registered output, so the record rate of the back end
// sets the sustained rate for columns with many short runs. Write full_size
// only between columns, while no records are outstanding. There is no
// clearing pass after reset.
module sorted_index_group_segmenter_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration write: full_size
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sigseg_pkg::FULL_SIZE_W-1:0]  csr_data,
   // Row input
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,   // index_value
   input  logic                                req_tlast,   // last_row
   // Record output
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // group_first, group_end, row_offset, row_count, error_code, zero fill
   output logic [sigseg_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [1:0]                          rsp_tuser,   // record_kind
   output logic                                rsp_tlast    // last_record
);

   logic [sigseg_pkg::FULL_SIZE_W-1:0] full_size_ff;
   logic                   row_accept, push, pop, q_not_empty, q_full;
   sigseg_pkg::entry_type  push_entry, head;
   sigseg_pkg::record_type rsp_rec;

   // Hold the group count register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset)
         full_size_ff <= '0;
      else if (csr_valid)
         full_size_ff <= csr_data;
   end

   assign req_tready = !q_full;
   assign row_accept = req_tvalid && req_tready;

   sigseg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .full_size   (full_size_ff),
      .row_accept  (row_accept),
      .index_value (req_tdata),
      .last_row    (req_tlast),
      .push        (push),
      .push_entry  (push_entry)
   );

   sigseg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   sigseg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (q_not_empty),
      .pop        (pop),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_rec    (rsp_rec)
   );

   // Pack the output word
   assign rsp_tdata = {5'b0, 3'(rsp_rec.err), rsp_rec.count, rsp_rec.offset,
                       rsp_rec.group_end, rsp_rec.first};
   assign rsp_tuser = 2'(rsp_rec.kind);
   assign rsp_tlast = rsp_rec.last;

   // An error record always ends the column
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_rec.kind == sigseg_pkg::KIND_ERROR) |-> rsp_rec.last)
      else $error("error record without last flag");

   // Empty ranges carry no rows and run forward
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_rec.kind == sigseg_pkg::KIND_RANGE) |->
      (rsp_rec.count == '0 && signed'(rsp_rec.first) <= signed'(rsp_rec.group_end)))
      else $error("malformed empty range record");

   // Only error records carry an error code
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_rec.kind != sigseg_pkg::KIND_ERROR) |->
      (rsp_rec.err == sigseg_pkg::ERR_NONE))
      else $error("error code on a non-error record");

   // No entry is written into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("entry pushed into full queue");

endmodule
